[src/usqt_pkg.sv]
// ============================================================================
// usqt_pkg
// Shared types, constants and helpers of the UV-sphere quad tessellator.
// ============================================================================
package usqt_pkg;

  // Grid geometry
  localparam int MAX_GRID_SIDE = 256;
  localparam int CNT_W         = $clog2(MAX_GRID_SIDE) + 1;  // count register width
  localparam int POS_W         = CNT_W - 1;                  // column / row width
  localparam int HALF_W        = POS_W - 1;                  // (count - 1) / 2
  localparam int RESET_COUNT   = 16;

  // Reciprocal ceil(2^32 / d) used for the exact angle quotients
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RESET_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RESET_COUNT - 2)) / 64'(RESET_COUNT - 1));

  // Fixed-point sine
  localparam int Q14_ONE = 16384;
  localparam int SIN_A   = 102944;
  localparam int SIN_B   = 42048;
  localparam int SIN_C   = 4640;

  // Output sequence
  localparam int CORNERS = 6;
  localparam int CORN_W  = $clog2(CORNERS);

  // Front/back queue
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_idx_e;

  // One classified quad: clamped position and wrapped neighbors
  typedef struct packed {
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] nc;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] nr;
  } quad_t;

  // Static grid settings handed to the back end
  typedef struct packed {
    logic [CNT_W-1:0]   rows;
    logic [HALF_W-1:0]  col_half;
    logic [HALF_W-1:0]  row_half;
    logic [RECIP_W-1:0] col_recip;
    logic [RECIP_W-1:0] row_recip;
  } grid_t;

  // Front status
  typedef struct packed {
    logic recip_busy;
    logic q_push;
  } fe_status_t;

  // Count clamp into 2 .. MAX_GRID_SIDE
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v < CNT_W'(2)) begin
      res = CNT_W'(2);
    end else if (v > CNT_W'(MAX_GRID_SIDE)) begin
      res = CNT_W'(MAX_GRID_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[src/usqt_queue.sv]
// ============================================================================
// usqt_queue
// Small FIFO of classified quads between the front and the back end.
// ============================================================================
module usqt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  usqt_pkg::quad_t   push_data_i,
  output logic              full_o,
  output logic              valid_o,
  output usqt_pkg::quad_t   data_o,
  input  logic              pop_i
);

  localparam int PTR_W = $clog2(usqt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(usqt_pkg::QUEUE_DEPTH + 1);

  usqt_pkg::quad_t mem_q [usqt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(usqt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(usqt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(usqt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[src/usqt_front.sv]
// ============================================================================
// usqt_front
// Configuration registers, reciprocal unit and input classification.
// ============================================================================
module usqt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [usqt_pkg::CNT_W-1:0]    cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [usqt_pkg::POS_W-1:0]    column_i,
  input  logic [usqt_pkg::POS_W-1:0]    row_i,
  // queue side
  output logic                          q_push_o,
  output usqt_pkg::quad_t               q_data_o,
  input  logic                          q_full_i,
  // to back end
  output usqt_pkg::grid_t               grid_o,
  output usqt_pkg::fe_status_t          status_o
);

  localparam int CNT_W   = usqt_pkg::CNT_W;
  localparam int POS_W   = usqt_pkg::POS_W;
  localparam int RECIP_W = usqt_pkg::RECIP_W;
  localparam int STEP_W  = $clog2(RECIP_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_ROWS,
    ST_DIV_ROWS,
    ST_LOAD_COLS,
    ST_DIV_COLS
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     row_count_q, column_count_q;
  logic [CNT_W-1:0]     rows_cl, cols_cl, rd9, cd9;
  logic [POS_W-1:0]     rd, cd, div_d;
  logic [RECIP_W-1:0]   num_q, quo_q, row_recip_q, col_recip_q;
  logic [POS_W-1:0]     rem_q;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     rem_sh, rem_sub;
  logic                 qbit;
  logic                 cfg_acc, in_acc;

  // Clamped counts and divisors
  always_comb begin
    rows_cl = usqt_pkg::clamp_count(row_count_q);
    cols_cl = usqt_pkg::clamp_count(column_count_q);
    rd9     = rows_cl - CNT_W'(1);
    cd9     = cols_cl - CNT_W'(1);
    rd      = rd9[POS_W-1:0];
    cd      = cd9[POS_W-1:0];
  end

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !q_full_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CNT_W'(usqt_pkg::RESET_COUNT);
      column_count_q <= CNT_W'(usqt_pkg::RESET_COUNT);
    end else if (cfg_acc) begin
      unique case (usqt_pkg::cfg_idx_e'(cfg_index_i))
        usqt_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        usqt_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default:                    row_count_q    <= row_count_q;
      endcase
    end
  end

  // Restoring divider step: one quotient bit per cycle
  always_comb begin
    div_d   = (state_q == ST_DIV_ROWS) ? rd : cd;
    rem_sh  = {rem_q, num_q[RECIP_W-1]};
    rem_sub = rem_sh - {1'b0, div_d};
    qbit    = (rem_sh >= {1'b0, div_d});
  end

  // Reciprocal sequencer: ceil(2^32 / d) for rows, then columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      row_recip_q <= usqt_pkg::RESET_RECIP;
      col_recip_q <= usqt_pkg::RESET_RECIP;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_acc) state_q <= ST_LOAD_ROWS;
        end
        ST_LOAD_ROWS, ST_LOAD_COLS: begin
          num_q   <= (RECIP_W'(1) << usqt_pkg::RECIP_SHIFT)
                     + RECIP_W'((state_q == ST_LOAD_ROWS) ? rd : cd) - RECIP_W'(1);
          quo_q   <= '0;
          rem_q   <= '0;
          step_q  <= STEP_W'(RECIP_W - 1);
          state_q <= (state_q == ST_LOAD_ROWS) ? ST_DIV_ROWS : ST_DIV_COLS;
        end
        ST_DIV_ROWS, ST_DIV_COLS: begin
          num_q  <= num_q << 1;
          rem_q  <= qbit ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
          quo_q  <= {quo_q[RECIP_W-2:0], qbit};
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            if (state_q == ST_DIV_ROWS) begin
              row_recip_q <= {quo_q[RECIP_W-2:0], qbit};
              state_q     <= ST_LOAD_COLS;
            end else begin
              col_recip_q <= {quo_q[RECIP_W-2:0], qbit};
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Classify: clamp position, wrap next column and row
  always_comb begin
    logic [CNT_W-1:0] c9, r9, nc9, nr9;
    c9  = ({1'b0, column_i} >= cols_cl) ? cd9 : {1'b0, column_i};
    r9  = ({1'b0, row_i} >= rows_cl) ? rd9 : {1'b0, row_i};
    nc9 = c9 + CNT_W'(1);
    nr9 = r9 + CNT_W'(1);
    q_data_o.c  = c9[POS_W-1:0];
    q_data_o.r  = r9[POS_W-1:0];
    q_data_o.nc = (nc9 == cols_cl) ? '0 : nc9[POS_W-1:0];
    q_data_o.nr = (nr9 == rows_cl) ? '0 : nr9[POS_W-1:0];
  end

  assign q_push_o = in_acc;

  // Static grid settings
  always_comb begin
    grid_o.rows      = rows_cl;
    grid_o.col_half  = cd[POS_W-1:1];
    grid_o.row_half  = rd[POS_W-1:1];
    grid_o.col_recip = col_recip_q;
    grid_o.row_recip = row_recip_q;
  end

  assign status_o.recip_busy = (state_q != ST_IDLE);
  assign status_o.q_push     = in_acc;

endmodule

[src/usqt_back.sv]
// ============================================================================
// usqt_back
// Corner sequencer and position pipeline: angles, sines, products.
// ============================================================================
module usqt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // queue side
  input  logic                          q_valid_i,
  input  usqt_pkg::quad_t               q_data_i,
  output logic                          q_pop_o,
  input  usqt_pkg::grid_t               grid_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   vertex_index_o,
  output logic signed [15:0]            pos_x_o,
  output logic signed [15:0]            pos_y_o,
  output logic signed [15:0]            pos_z_o,
  output logic                          last_o
);

  localparam int POS_W   = usqt_pkg::POS_W;
  localparam int CNT_W   = usqt_pkg::CNT_W;
  localparam int RECIP_W = usqt_pkg::RECIP_W;
  localparam int SH      = usqt_pkg::RECIP_SHIFT;
  localparam int CORN_W  = usqt_pkg::CORN_W;
  localparam int LANES   = 4;   // sin theta, cos theta, cos phi, sin phi
  localparam int NP_W    = POS_W + 16;
  localparam int NT_W    = POS_W + 15;

  logic adv, issue;
  logic [CORN_W-1:0] corner_q;

  // pipeline valids
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic s0_l_q, s1_l_q, s2_l_q, s3_l_q, s4_l_q, s5_l_q;
  logic [POS_W-1:0] s0_col_q, s0_row_q, sel_col, sel_row;
  logic [15:0] s1_vi_q, s2_vi_q, s3_vi_q, s4_vi_q, s5_vi_q;
  logic [16:0] s1_phi_q;
  logic [15:0] s1_th_q;
  logic [14:0] s2_z_q  [LANES];
  logic [14:0] s2_zz_q [LANES];
  logic [14:0] s3_z_q  [LANES];
  logic [14:0] s3_zz_q [LANES];
  logic [15:0] s3_in_q [LANES];
  logic [14:0] s4_z_q  [LANES];
  logic [16:0] s4_out_q[LANES];
  logic        s2_n_q[LANES], s3_n_q[LANES], s4_n_q[LANES];
  logic signed [15:0] s5_s_q[LANES];

  // whole pipeline moves unless the output register is held
  assign adv     = !s6_v_q || out_ready_i;
  assign issue   = adv && q_valid_i;
  assign q_pop_o = issue && (corner_q == CORN_W'(usqt_pkg::CORNERS - 1));

  // Corner order a, d, c, a, b, d
  always_comb begin
    unique case (corner_q)
      CORN_W'(0): begin sel_col = q_data_i.c;  sel_row = q_data_i.r;  end
      CORN_W'(1): begin sel_col = q_data_i.nc; sel_row = q_data_i.nr; end
      CORN_W'(2): begin sel_col = q_data_i.nc; sel_row = q_data_i.r;  end
      CORN_W'(3): begin sel_col = q_data_i.c;  sel_row = q_data_i.r;  end
      CORN_W'(4): begin sel_col = q_data_i.c;  sel_row = q_data_i.nr; end
      default:    begin sel_col = q_data_i.nc; sel_row = q_data_i.nr; end
    endcase
  end

  // Control: corner counter and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      s0_v_q <= 1'b0; s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      s4_v_q <= 1'b0; s5_v_q <= 1'b0; s6_v_q <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        corner_q <= q_pop_o ? '0 : corner_q + 1'b1;
      end
      s0_v_q <= q_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  // Stage 0: selected corner
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_col_q <= sel_col;
      s0_row_q <= sel_row;
      s0_l_q   <= (corner_q == CORN_W'(usqt_pkg::CORNERS - 1));
    end
  end

  // Stage 1: exact quotients by reciprocal multiply, grid index
  always_ff @(posedge clk_i) begin
    logic [NP_W-1:0] n_phi;
    logic [NT_W-1:0] n_th;
    logic [NP_W+RECIP_W-1:0] p_phi;
    logic [NT_W+RECIP_W-1:0] p_th;
    logic [POS_W+CNT_W-1:0] vi;
    n_phi = {s0_col_q, 16'd0} + NP_W'(grid_i.col_half);
    n_th  = {s0_row_q, 15'd0} + NT_W'(grid_i.row_half);
    p_phi = NP_W'(n_phi) * (NP_W + RECIP_W)'(grid_i.col_recip);
    p_th  = (NT_W + RECIP_W)'(n_th) * (NT_W + RECIP_W)'(grid_i.row_recip);
    vi    = (POS_W + CNT_W)'(s0_col_q) * (POS_W + CNT_W)'(grid_i.rows)
            + (POS_W + CNT_W)'(s0_row_q);
    if (adv) begin
      s1_phi_q <= p_phi[SH+16:SH];
      s1_th_q  <= p_th[SH+15:SH];
      s1_vi_q  <= vi[15:0];
      s1_l_q   <= s0_l_q;
    end
  end

  // Stage 2: phases to quarter-wave arguments, z squared
  always_ff @(posedge clk_i) begin
    logic [15:0] theta, phi;
    logic [15:0] ph [LANES];
    logic [14:0] zf;
    logic [29:0] sq;
    theta = s1_th_q + 16'hC000;
    phi   = s1_phi_q[15:0];
    ph[0] = theta;
    ph[1] = theta + 16'(usqt_pkg::Q14_ONE);
    ph[2] = phi + 16'(usqt_pkg::Q14_ONE);
    ph[3] = phi;
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        zf = ph[i][14] ? 15'(usqt_pkg::Q14_ONE) - {1'b0, ph[i][13:0]}
                       : {1'b0, ph[i][13:0]};
        sq = 30'(zf) * 30'(zf);
        s2_z_q[i]  <= zf;
        s2_zz_q[i] <= sq[28:14];
        s2_n_q[i]  <= ph[i][15];
      end
      s2_vi_q <= s1_vi_q;
      s2_l_q  <= s1_l_q;
    end
  end

  // Stage 3: inner term B - C*z^2
  always_ff @(posedge clk_i) begin
    logic [27:0] t;
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        t = 28'(usqt_pkg::SIN_C) * 28'(s2_zz_q[i]);
        s3_in_q[i] <= 16'(usqt_pkg::SIN_B) - 16'(t[27:14]);
        s3_z_q[i]  <= s2_z_q[i];
        s3_zz_q[i] <= s2_zz_q[i];
        s3_n_q[i]  <= s2_n_q[i];
      end
      s3_vi_q <= s2_vi_q;
      s3_l_q  <= s2_l_q;
    end
  end

  // Stage 4: outer term A - inner*z^2
  always_ff @(posedge clk_i) begin
    logic [30:0] t;
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        t = 31'(s3_in_q[i]) * 31'(s3_zz_q[i]);
        s4_out_q[i] <= 17'(usqt_pkg::SIN_A) - 17'(t[30:14]);
        s4_z_q[i]   <= s3_z_q[i];
        s4_n_q[i]   <= s3_n_q[i];
      end
      s4_vi_q <= s3_vi_q;
      s4_l_q  <= s3_l_q;
    end
  end

  // Stage 5: final product, rounded, sign of the half wave
  always_ff @(posedge clk_i) begin
    logic [31:0] t;
    logic [15:0] m;
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        t = 32'(s4_out_q[i]) * 32'(s4_z_q[i]) + 32'd32768;
        m = t[31:16];
        s5_s_q[i] <= s4_n_q[i] ? -$signed(m) : $signed(m);
      end
      s5_vi_q <= s4_vi_q;
      s5_l_q  <= s4_l_q;
    end
  end

  // Q1.14 product, magnitude rounded, sign applied after
  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic [15:0] ma, mb, m;
    logic [31:0] p;
    ma = a[15] ? 16'(-a) : 16'(a);
    mb = b[15] ? 16'(-b) : 16'(b);
    p  = 32'(ma) * 32'(mb) + 32'd8192;
    m  = p[29:14];
    return (a[15] != b[15]) ? -$signed(m) : $signed(m);
  endfunction

  // Stage 6: output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o        <= mul_q14(s5_s_q[1], s5_s_q[2]);
      pos_y_o        <= mul_q14(s5_s_q[1], s5_s_q[3]);
      pos_z_o        <= s5_s_q[0];
      vertex_index_o <= s5_vi_q;
      last_o         <= s5_l_q;
    end
  end

  assign out_valid_o = s6_v_q;

endmodule

[src/uv_sphere_quad_tessellator.sv]
// ============================================================================
// uv_sphere_quad_tessellator
// Emits the six triangle corners of one latitude/longitude sphere quad.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one quad as column_i, row_i.
//   Output channel (out_valid_o/out_ready_i) returns six corner items in
//   the order a, d, c, a, b, d, each with its grid index, a Q1.14 position
//   and last_o high on the sixth.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes row_count
//   (index 0) or column_count (index 1). Each write starts a reciprocal
//   computation (two 33-step serial dividers plus loads); during it
//   neither a write nor a quad is taken.
//   Throughput: one corner per cycle while the receiver is ready, six per
//   quad, set by the corner sequencer feeding the 7-stage position pipeline.
//   A two-entry quad queue lets new quads in while corners are pending.
//   Reset: counts return to 16 with their reciprocals preloaded, so quads
//   are taken right after reset.
//   Receiver stall: the output register holds and the whole position
//   pipeline freezes; the queue keeps accepting until full.
// ============================================================================
module uv_sphere_quad_tessellator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [usqt_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [usqt_pkg::POS_W-1:0]    column_i,
  input  logic [usqt_pkg::POS_W-1:0]    row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   vertex_index_o,
  output logic signed [15:0]            pos_x_o,
  output logic signed [15:0]            pos_y_o,
  output logic signed [15:0]            pos_z_o,
  output logic                          last_o
);

  logic                   q_push, q_full, q_valid, q_pop;
  usqt_pkg::quad_t        q_wdata, q_rdata;
  usqt_pkg::grid_t        grid;
  usqt_pkg::fe_status_t   fe_status;

  usqt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full),
    .grid_o      (grid),
    .status_o    (fe_status)
  );

  usqt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_rdata),
    .pop_i       (q_pop)
  );

  usqt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .grid_i         (grid),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vertex_index_o (vertex_index_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .last_o         (last_o)
  );

  // Queue never takes a quad while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_status.q_push |-> !q_full)
    else $error("quad queue overflow");

  // No quad enters while reciprocals are being rebuilt
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_status.recip_busy |-> !in_ready_o && !fe_status.q_push)
    else $error("quad taken during reciprocal update");

  // Pop only from a non-empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // Z position stays within the unit sphere range
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pos_z_o <= 16'sd16384) && (pos_z_o >= -16'sd16384))
    else $error("pos_z out of range");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// uv_sphere_quad_tessellator testbench
// Drives quads and grid-size writes, predicts the six corners of each quad
// with a fixed-point sphere model and checks every corner item in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] vertex_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic        last;
  } corner_t;

  // Corner predictor and queue of expected corners
  class corner_scoreboard;
    int unsigned rows_reg = usqt_pkg::RESET_COUNT;
    int unsigned cols_reg = usqt_pkg::RESET_COUNT;
    corner_t     pending[$];
    int          errors;

    function void write_reg(usqt_pkg::cfg_idx_e idx, int unsigned val);
      if (idx == usqt_pkg::CFG_ROW_COUNT) rows_reg = val & 9'h1FF;
      else cols_reg = val & 9'h1FF;
    endfunction

    function int unsigned limit_count(int unsigned v);
      if (v < 2) return 2;
      if (v > usqt_pkg::MAX_GRID_SIDE) return usqt_pkg::MAX_GRID_SIDE;
      return v;
    endfunction

    function longint quarter_wave(longint z);
      longint zz, inr, outr;
      zz   = (z * z) >> 14;
      inr  = usqt_pkg::SIN_B - ((usqt_pkg::SIN_C * zz) >> 14);
      outr = usqt_pkg::SIN_A - ((inr * zz) >> 14);
      return (outr * z + 32768) >> 16;
    endfunction

    function longint sine_of(longint phase);
      longint p, q, z, s;
      p = phase & 16'hFFFF;
      q = p >> 14;
      z = p & 14'h3FFF;
      s = q[0] ? quarter_wave(usqt_pkg::Q14_ONE - z) : quarter_wave(z);
      return q[1] ? -s : s;
    endfunction

    function longint q14_product(longint a, longint b);
      longint m;
      m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 8192) >> 14;
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function corner_t make_corner(int unsigned c, int unsigned r, int unsigned cols,
                                  int unsigned rows, bit lst);
      corner_t k;
      longint cd, rd, phi, theta, ct, st, cp, sp;
      cd    = cols - 1;
      rd    = rows - 1;
      phi   = (((longint'(c) << 16) + cd / 2) / cd) & 16'hFFFF;
      theta = ((((longint'(r) << 15) + rd / 2) / rd) + 49152) & 16'hFFFF;
      ct = sine_of(theta + usqt_pkg::Q14_ONE);
      st = sine_of(theta);
      cp = sine_of(phi + usqt_pkg::Q14_ONE);
      sp = sine_of(phi);
      k.vertex_index = 16'(c * rows + r);
      k.pos_x = 16'(q14_product(ct, cp));
      k.pos_y = 16'(q14_product(ct, sp));
      k.pos_z = 16'(st);
      k.last  = lst;
      return k;
    endfunction

    // Note an accepted quad: queue its six corners a, d, c, a, b, d
    function void note_quad(int unsigned col, int unsigned row);
      int unsigned rows, cols, c, r, nc, nr;
      int unsigned cc[6], rr[6];
      rows = limit_count(rows_reg);
      cols = limit_count(cols_reg);
      c = (col >= cols) ? cols - 1 : col;
      r = (row >= rows) ? rows - 1 : row;
      nc = (c + 1 == cols) ? 0 : c + 1;
      nr = (r + 1 == rows) ? 0 : r + 1;
      cc = '{c, nc, nc, c, c, nc};
      rr = '{r, nr, r, r, nr, nr};
      for (int i = 0; i < 6; i++)
        pending.insert(pending.size(), make_corner(cc[i], rr[i], cols, rows, i == 5));
    endfunction

    // Check one accepted corner against the oldest expectation
    function void check_corner(corner_t got);
      corner_t e;
      if (pending.size() == 0) begin
        $error("unexpected corner item, index %0d", got.vertex_index);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.vertex_index !== e.vertex_index) begin
        $error("vertex_index exp %0d got %0d", e.vertex_index, got.vertex_index); errors++;
      end
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", $signed(e.pos_x), $signed(got.pos_x)); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", $signed(e.pos_y), $signed(got.pos_y)); errors++;
      end
      if (got.pos_z !== e.pos_z) begin
        $error("pos_z exp %0d got %0d", $signed(e.pos_z), $signed(got.pos_z)); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, in_valid_i = 0, out_ready_i = 0;
  logic cfg_ready_o, in_ready_o, out_valid_o, last_o;
  logic [0:0] cfg_index_i = 0;
  logic [usqt_pkg::CNT_W-1:0] cfg_data_i = 0;
  logic [usqt_pkg::POS_W-1:0] column_i = 0, row_i = 0;
  logic [15:0] vertex_index_o;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o;

  corner_scoreboard sb = new();
  int idle_cycles;
  bit noisy_rx = 1;

  uv_sphere_quad_tessellator DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int gap_len();
    int k = $urandom_range(0, 9);
    if (k < 5) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls while noisy_rx is set, check at each accepted corner
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_corner('{vertex_index_o, pos_x_o, pos_y_o, pos_z_o, last_o});
    out_ready_i <= noisy_rx ? ($urandom_range(0, 9) < 7) : 1'b1;
  end

  // Watchdog over cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("uv_sphere_quad_tessellator verification failed");
      $finish;
    end
  end

  // Valid stays high across back-to-back quads; it drops only before a gap or a drain
  task automatic send_quad(int unsigned col, int unsigned row);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    column_i   <= usqt_pkg::POS_W'(col);
    row_i      <= usqt_pkg::POS_W'(row);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_quad(col, row);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(usqt_pkg::cfg_idx_e idx, int unsigned val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= usqt_pkg::CNT_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  task automatic random_phase(int n, int unsigned rows, int unsigned cols);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_quad($urandom_range(0, 255), $urandom_range(0, 255));
      else send_quad($urandom_range(0, sb.limit_count(cols) - 1),
                     $urandom_range(0, sb.limit_count(rows) - 1));
    end
  endtask

  initial begin
    int unsigned rs, cs;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset grid, corners, wrap, out-of-range positions
    send_quad(0, 0);
    send_quad(15, 15);
    send_quad(7, 3);
    send_quad(255, 255);
    send_quad(8'hAA, 8'h55);
    send_quad(8'h55, 8'hAA);
    // sender holds off until all corners are back
    drain();
    write_reg(usqt_pkg::CFG_ROW_COUNT, 2);
    write_reg(usqt_pkg::CFG_COLUMN_COUNT, 2);
    send_quad(0, 0); send_quad(1, 1); send_quad(200, 3);
    write_reg(usqt_pkg::CFG_ROW_COUNT, 256);
    write_reg(usqt_pkg::CFG_COLUMN_COUNT, 256);
    send_quad(0, 0); send_quad(255, 255); send_quad(128, 127); send_quad(254, 0);
    write_reg(usqt_pkg::CFG_ROW_COUNT, 0);
    write_reg(usqt_pkg::CFG_COLUMN_COUNT, 511);
    send_quad(0, 1); send_quad(255, 255); send_quad(3, 0);
    write_reg(usqt_pkg::CFG_ROW_COUNT, 1);
    write_reg(usqt_pkg::CFG_COLUMN_COUNT, 257);
    send_quad(100, 0); send_quad(255, 1);

    // Random phases over several grid sizes
    for (int ph = 0; ph < 6; ph++) begin
      rs = (ph == 5) ? 16 : $urandom_range(0, 300);
      cs = (ph == 5) ? 16 : $urandom_range(0, 300);
      noisy_rx = (ph != 2);
      write_reg(usqt_pkg::CFG_ROW_COUNT, rs);
      write_reg(usqt_pkg::CFG_COLUMN_COUNT, cs);
      random_phase(17, rs, cs);
    end
    noisy_rx = 1;

    drain();
    if (sb.errors == 0) $display("uv_sphere_quad_tessellator verification clean");
    else $display("uv_sphere_quad_tessellator verification failed");
    $finish;
  end
endmodule
